@@ sv/bffa_pkg.sv @@
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and codes for the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

  // Request operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

  // Outcome of scanning one bitmap byte for the end of a free run
  typedef struct packed {
    logic       found;
    logic [2:0] bit_idx;
  } scan_hit_t;

  // Number of set bits in a bitmap byte
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/bffa_ifs.sv @@
// ----------------------------------------------------------------------------
// bffa request and response channels
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [12:0] size;
  logic [11:0] offset;

  modport source (output valid, output operation, output size, output offset,
                  input ready);
  modport sink   (input valid, input operation, input size, input offset,
                  output ready);
endinterface

interface bffa_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [11:0] alloc_offset;
  logic [12:0] used_bytes;

  modport source (output valid, output ok, output alloc_offset, output used_bytes,
                  input ready);
  modport sink   (input valid, input ok, input alloc_offset, input used_bytes,
                  output ready);
endinterface

`default_nettype wire

@@ sv/bffa_map_ram.sv @@
// ----------------------------------------------------------------------------
// bffa_map_ram
// Usage bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_map_ram #(
  parameter int WORDS = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [WORDS];

  // Write one byte, read one byte each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/bffa_word_scan.sv @@
// ----------------------------------------------------------------------------
// bffa_word_scan
// Extends the current free run through one bitmap byte, MSB first, and flags
// the first bit at which the run reaches the requested length.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_word_scan #(
  parameter int POOL_BYTES = 4096,
  parameter int AW         = 9,
  parameter int XW         = 14
) (
  input  wire logic [7:0]    data,
  input  wire logic [AW-1:0] word,
  input  wire logic [XW-1:0] run_in,
  input  wire logic [XW-1:0] len,
  output logic      [XW-1:0] run_out,
  output bffa_pkg::scan_hit_t hit
);

  localparam logic [XW-1:0] POOL_X = XW'(POOL_BYTES);

  // Walk the eight bits; bits past the pool end count as used
  always_comb begin
    logic [3:0]    loc;
    logic          all_clr;
    logic          taken;
    logic [XW-1:0] run_k;
    loc     = 4'd0;
    all_clr = 1'b1;
    hit     = '0;
    run_out = run_in;
    for (int k = 0; k < 8; k++) begin
      taken = data[7-k] || (XW'({word, 3'(k)}) >= POOL_X);
      if (taken) begin
        loc     = 4'd0;
        all_clr = 1'b0;
      end else begin
        loc = loc + 4'd1;
      end
      run_k = all_clr ? run_in + XW'(k + 1) : XW'(loc);
      if (!hit.found && !taken && run_k == len) begin
        hit.found   = 1'b1;
        hit.bit_idx = 3'(k);
      end
      run_out = run_k;
    end
  end

endmodule

`default_nettype wire

@@ sv/bitmap_first_fit_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top
// Byte-granular first-fit pool allocator over a usage bitmap held in RAM.
// ----------------------------------------------------------------------------
// Allocate scans bitmap bytes up to the run end, then marks the bytes of the run.
// Free marks the bytes of its region; query, invalid code and rejected sizes
//   go straight to the response.
// One request in flight, one bitmap byte per cycle; the next request is taken
//   the cycle after the response loads.
// After reset a clearing pass zeroes the bitmap;
//   requests are held off until it ends.
`default_nettype none

module bitmap_first_fit_allocator_top #(
  parameter int POOL_BYTES = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bffa_req_if.sink    req,
  bffa_rsp_if.source  rsp
);

  localparam int MAP_WORDS = (POOL_BYTES + 7) / 8;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(POOL_BYTES + 1);
  localparam int XW        = ((CW > 13) ? CW : 13) + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [XW-1:0] POOL_X    = XW'(POOL_BYTES);

  bffa_pkg::state_t    state, state_next;
  bffa_pkg::scan_hit_t hit;

  logic [1:0]    op;
  logic [XW-1:0] len, lo, hi, run, run_out;
  logic [AW-1:0] ra, pw, last_w;
  logic          more, pv, res_ok;
  logic [CW-1:0] used;

  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd, rd_data;

  logic          accept, load;
  logic [XW-1:0] req_size_x, req_off_x, free_end, free_hi, hi_m1;
  logic          alloc_bad;
  logic [XW-1:0] hit_pos, hit_start;
  logic [7:0]    mask;
  logic          mark_end;

  logic          rsp_valid, rsp_ok;
  logic [11:0]   rsp_off;
  logic [12:0]   rsp_used;

  // Bitmap storage
  bffa_map_ram #(.WORDS(MAP_WORDS), .AW(AW)) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rd_data)
  );

  // Run search over the byte just read
  bffa_word_scan #(.POOL_BYTES(POOL_BYTES), .AW(AW), .XW(XW)) u_scan (
    .data    (rd_data),
    .word    (pw),
    .run_in  (run),
    .len     (len),
    .run_out (run_out),
    .hit     (hit)
  );

  // Decode the incoming request
  assign req_size_x = XW'(req.size);
  assign req_off_x  = XW'(req.offset);
  assign free_end   = req_off_x + req_size_x;
  assign free_hi    = (free_end > POOL_X) ? POOL_X : free_end;
  assign alloc_bad  = (req.size == 13'd0) || (req_size_x > POOL_X);
  assign accept     = req.valid && req.ready;

  // Run position found by the scan
  assign hit_pos   = XW'({pw, hit.bit_idx});
  assign hit_start = hit_pos + XW'(1) - len;

  // Mask of bits in [lo, hi) inside byte pw
  assign hi_m1    = hi - XW'(1);
  assign last_w   = hi_m1[AW+2:3];
  assign mark_end = pv && (pw == last_w);
  always_comb begin
    mask = 8'hFF;
    if (pw == lo[AW+2:3]) begin
      mask = mask & (8'hFF >> lo[2:0]);
    end
    if (pw == last_w) begin
      mask = mask & (8'hFF << (3'd7 - hi_m1[2:0]));
    end
  end

  assign load = (state == bffa_pkg::ST_DONE) && (!rsp_valid || rsp.ready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bffa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM write port and request ready
  always_comb begin
    state_next = state;
    we         = 1'b0;
    wa         = pw;
    wd         = 8'h00;
    req.ready  = 1'b0;
    case (state)
      bffa_pkg::ST_CLEAR: begin
        we = 1'b1;
        wa = ra;
        if (ra == LAST_WORD) begin
          state_next = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.operation)
            bffa_pkg::OP_ALLOC: begin
              state_next = alloc_bad ? bffa_pkg::ST_DONE : bffa_pkg::ST_SCAN;
            end
            bffa_pkg::OP_FREE: begin
              state_next = (req_off_x >= free_hi) ? bffa_pkg::ST_DONE
                                                  : bffa_pkg::ST_MARK;
            end
            default: begin
              state_next = bffa_pkg::ST_DONE;
            end
          endcase
        end
      end
      bffa_pkg::ST_SCAN: begin
        if (pv && hit.found) begin
          state_next = bffa_pkg::ST_MARK;
        end else if (pv && pw == LAST_WORD) begin
          state_next = bffa_pkg::ST_DONE;
        end
      end
      bffa_pkg::ST_MARK: begin
        if (pv) begin
          we = 1'b1;
          wd = (op == bffa_pkg::OP_ALLOC) ? (rd_data | mask) : (rd_data & ~mask);
        end
        if (mark_end) begin
          state_next = bffa_pkg::ST_DONE;
        end
      end
      bffa_pkg::ST_DONE: begin
        if (load) begin
          state_next = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath: read issue, run tracking, region bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      ra <= '0;
    end else begin
      case (state)
        bffa_pkg::ST_CLEAR: begin
          ra <= ra + AW'(1);
        end
        bffa_pkg::ST_IDLE: begin
          if (accept) begin
            op     <= req.operation;
            len    <= req_size_x;
            run    <= '0;
            pv     <= 1'b0;
            more   <= 1'b1;
            res_ok <= (req.operation == bffa_pkg::OP_FREE) ||
                      (req.operation == bffa_pkg::OP_QUERY);
            if (req.operation == bffa_pkg::OP_ALLOC) begin
              ra <= '0;
            end else begin
              ra <= req_off_x[AW+2:3];
              lo <= req_off_x;
              hi <= free_hi;
            end
          end
        end
        bffa_pkg::ST_SCAN: begin
          pv <= more;
          if (more) begin
            pw   <= ra;
            ra   <= ra + AW'(1);
            more <= (ra != LAST_WORD);
          end
          if (pv) begin
            run <= run_out;
            // Restart the reads at the start of the run to mark it
            if (hit.found) begin
              lo     <= hit_start;
              hi     <= hit_pos + XW'(1);
              ra     <= hit_start[AW+2:3];
              pv     <= 1'b0;
              more   <= 1'b1;
              res_ok <= 1'b1;
            end
          end
        end
        bffa_pkg::ST_MARK: begin
          pv <= more;
          if (more) begin
            pw   <= ra;
            ra   <= ra + AW'(1);
            more <= (ra != last_w);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Used-byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == bffa_pkg::ST_MARK && pv) begin
      if (op == bffa_pkg::OP_ALLOC) begin
        if (mark_end) begin
          used <= used + CW'(len);
        end
      end else begin
        used <= used - CW'(bffa_pkg::popcount8(rd_data & mask));
      end
    end
  end

  // Response register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_ok   <= res_ok;
      rsp_off  <= (op == bffa_pkg::OP_ALLOC && res_ok) ? lo[11:0] : 12'd0;
      rsp_used <= 13'(used);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.ok           = rsp_ok;
  assign rsp.alloc_offset = rsp_off;
  assign rsp.used_bytes   = rsp_used;

endmodule

`default_nettype wire

@@ sv/bffa_checker.sv @@
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_checker #(
  parameter int POOL_BYTES = 4096
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_ok,
  input wire logic [11:0] rsp_alloc_offset,
  input wire logic [12:0] rsp_used_bytes
);

  localparam logic BIG_POOL = (POOL_BYTES > 8191);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_alloc_offset) && $stable(rsp_used_bytes))
    else $error("stalled response changed");

  // Failed responses carry a zero offset
  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_alloc_offset == 12'd0)
    else $error("failed response with nonzero offset");

  // Used count never exceeds the pool
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> BIG_POOL || (rsp_used_bytes <= 13'(POOL_BYTES)))
    else $error("used byte count above pool size");

  // The bitmap clearing pass holds off requests right after reset
  a_reset_hold: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("request taken during bitmap clear");

endmodule

bind bitmap_first_fit_allocator_top bffa_checker #(.POOL_BYTES(POOL_BYTES)) u_bffa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_ok           (rsp.ok),
  .rsp_alloc_offset (rsp.alloc_offset),
  .rsp_used_bytes   (rsp.used_bytes)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bitmap first-fit allocator testbench
// Drives allocate, free, query and invalid requests through the valid/ready
// request channel, tracks the pool usage map and used-byte count alongside
// the block, and checks every response field against the tracked state.
// ----------------------------------------------------------------------------

module tb;

  localparam int POOL_BYTES = 4096;
  localparam logic [1:0] OP_INVALID = 2'd3;
  localparam int RANDOM_ITEMS = 1170;
  localparam int PHASE_ITEMS = 150;
  localparam int DRAIN_CYCLES = 40;

  // One response as the block should produce it
  typedef struct packed {
    logic        ok;
    logic [11:0] alloc_offset;
    logic [12:0] used_bytes;
  } alloc_result_t;

  // A region handed out by a successful allocate
  typedef struct {
    int unsigned base;
    int unsigned len;
  } region_t;

  // Tracks pool usage per byte and holds the responses still owed
  class pool_ledger;
    bit            used_map [POOL_BYTES];
    int unsigned   used_count;
    alloc_result_t awaited_results [$];
    int unsigned   fail_count;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_count = 0;
      fail_count = 0;
    endfunction

    // Apply one accepted request and queue the response it must produce
    function alloc_result_t note_request(logic [1:0] op, logic [12:0] size,
                                         logic [11:0] offset);
      alloc_result_t res;
      int unsigned   run;
      int unsigned   start;
      int unsigned   stop;
      bit            found;
      res = '0;
      found = 1'b0;
      start = 0;
      if (op == bffa_pkg::OP_ALLOC) begin
        if (size != 0 && size <= POOL_BYTES) begin
          // First fit: a used byte restarts the run just past itself
          run = 0;
          for (int p = 0; p < POOL_BYTES && !found; p++) begin
            if (used_map[p]) begin
              run = 0;
            end else begin
              run++;
              if (run == size) begin
                start = p + 1 - size;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            for (int p = start; p < start + size; p++) used_map[p] = 1'b1;
            used_count += size;
            res.ok = 1'b1;
            res.alloc_offset = start[11:0];
          end
        end
      end else if (op == bffa_pkg::OP_FREE) begin
        // Clamp at the pool end; clear bytes only count when they were used
        stop = offset + size;
        if (stop > POOL_BYTES) stop = POOL_BYTES;
        for (int p = offset; p < stop; p++) begin
          if (used_map[p]) begin
            used_map[p] = 1'b0;
            used_count--;
          end
        end
        res.ok = 1'b1;
      end else if (op == bffa_pkg::OP_QUERY) begin
        res.ok = 1'b1;
      end
      res.used_bytes = used_count[12:0];
      awaited_results.push_back(res);
      return res;
    endfunction

    // Compare one response with the oldest owed one
    function void check_response(logic ok, logic [11:0] alloc_offset,
                                 logic [12:0] used_bytes);
      alloc_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: response with none awaited: ok %0d alloc_offset %0d used_bytes %0d",
                 $time, ok, alloc_offset, used_bytes);
        fail_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (ok !== want.ok) begin
        $display("%0t: ok mismatch: expected %0d actual %0d", $time, want.ok, ok);
        fail_count++;
      end
      if (alloc_offset !== want.alloc_offset) begin
        $display("%0t: alloc_offset mismatch: expected %0d actual %0d",
                 $time, want.alloc_offset, alloc_offset);
        fail_count++;
      end
      if (used_bytes !== want.used_bytes) begin
        $display("%0t: used_bytes mismatch: expected %0d actual %0d",
                 $time, want.used_bytes, used_bytes);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bffa_req_if req_ch ();
  bffa_rsp_if rsp_ch ();

  pool_ledger ledger;
  region_t    live_regions [$];
  int         req_gap_pct;
  int         rsp_stall_pct;

  bitmap_first_fit_allocator_top #(
    .POOL_BYTES(POOL_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock and reset
  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  initial begin
    #(120_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Response ready with random stall bursts
  initial begin : rsp_ready_gen
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every accepted response
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      ledger.check_response(rsp_ch.ok, rsp_ch.alloc_offset, rsp_ch.used_bytes);
    end
  end

  // Issue one request, with an optional idle burst first; valid stays high on return
  task automatic send_request(logic [1:0] op, logic [12:0] size, logic [11:0] offset);
    alloc_result_t res;
    region_t       reg_new;
    if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.size <= size;
    req_ch.offset <= offset;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    res = ledger.note_request(op, size, offset);
    if (op == bffa_pkg::OP_ALLOC && res.ok) begin
      reg_new.base = res.alloc_offset;
      reg_new.len = size;
      live_regions.push_back(reg_new);
    end
  endtask

  // Hold the request channel until every owed response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(posedge clk);
  endtask

  // Mostly small allocations, a few large ones and some invalid sizes
  function automatic logic [12:0] pick_alloc_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return 13'd0;
    if (roll < 4) return 13'($urandom_range(POOL_BYTES + 1, 8191));
    if (roll < 7) return 13'($urandom_range(1025, POOL_BYTES));
    if (roll < 15) return 13'($urandom_range(129, 1024));
    if (roll < 40) return 13'($urandom_range(17, 128));
    return 13'($urandom_range(1, 16));
  endfunction

  function automatic logic [12:0] pick_free_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 13'($urandom_range(0, 64));
    if (roll < 90) return 13'($urandom_range(65, 1024));
    return 13'($urandom_range(0, 8191));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int      roll;
    int      idx;
    region_t pick;
    ledger = new();
    req_gap_pct = 15;
    rsp_stall_pct = 8;
    req_ch.valid <= 1'b0;
    req_ch.operation <= bffa_pkg::OP_QUERY;
    req_ch.size <= '0;
    req_ch.offset <= '0;
    @(negedge rst);
    @(posedge clk);

    // Directed: size limits, full pool, pool end, clamped and idle frees
    send_request(bffa_pkg::OP_QUERY, 13'd0, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd0, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd4097, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd8191, 12'd4095);
    send_request(bffa_pkg::OP_ALLOC, 13'd4096, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_request(bffa_pkg::OP_QUERY, 13'd8191, 12'd4095);
    send_request(bffa_pkg::OP_FREE, 13'd8191, 12'd4095);
    send_request(bffa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd4096, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd50, 12'd100);
    send_request(bffa_pkg::OP_FREE, 13'd0, 12'd0);
    // Holes behind used bytes: the scan must restart just past each used byte
    send_request(bffa_pkg::OP_ALLOC, 13'd3, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd5, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd1, 12'd1);
    send_request(bffa_pkg::OP_ALLOC, 13'd2, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd2, 12'd4);
    send_request(bffa_pkg::OP_ALLOC, 13'd2, 12'd0);
    send_request(OP_INVALID, 13'd8191, 12'd4095);
    send_request(OP_INVALID, 13'd0, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd8191, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd4095, 12'd4095);
    send_request(bffa_pkg::OP_ALLOC, 13'd1, 12'd0);
    send_request(bffa_pkg::OP_ALLOC, 13'd2, 12'd0);
    send_request(bffa_pkg::OP_FREE, 13'd4096, 12'd0);
    live_regions.delete();

    // Random: mostly allocate/free pairs, with noise frees and odd codes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        if (n >= RANDOM_ITEMS - PHASE_ITEMS) begin
          req_gap_pct = 0;
          rsp_stall_pct = 0;
        end else begin
          req_gap_pct = pick_pct();
          rsp_stall_pct = pick_pct();
        end
        if (n == 2 * PHASE_ITEMS || n == 5 * PHASE_ITEMS) wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (ledger.used_count > 3300 && live_regions.size() != 0 && roll < 50) roll = 99;
      if (roll < 8) begin
        send_request(bffa_pkg::OP_QUERY, 13'($urandom_range(0, 8191)),
                     12'($urandom_range(0, 4095)));
      end else if (roll < 12) begin
        send_request(OP_INVALID, 13'($urandom_range(0, 8191)), 12'($urandom_range(0, 4095)));
      end else if (roll < 55) begin
        send_request(bffa_pkg::OP_ALLOC, pick_alloc_size(), 12'($urandom_range(0, 4095)));
      end else if (live_regions.size() != 0 && $urandom_range(0, 99) < 80) begin
        idx = $urandom_range(0, live_regions.size() - 1);
        pick = live_regions[idx];
        live_regions.delete(idx);
        send_request(bffa_pkg::OP_FREE, 13'(pick.len), 12'(pick.base));
      end else begin
        send_request(bffa_pkg::OP_FREE, pick_free_size(), 12'($urandom_range(0, 4095)));
      end
    end

    // Drain, let the block settle, then report
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.fail_count == 0 && ledger.awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
